### sv/sample_dispersion_metric_macros.svh
// Assertion macros for the sample dispersion metric block.
// No dependencies; included by modules that carry assertions.
`ifndef SAMPLE_DISPERSION_METRIC_MACROS_SVH
`define SAMPLE_DISPERSION_METRIC_MACROS_SVH
`ifndef ASSERT_OFF
`define SDM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SDM_ASSERT_R(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SDM_ASSERT(label, clk, rst, prop, msg)
`define SDM_ASSERT_R(label, clk, prop, msg)
`endif
`endif

### sv/sdm_pkg.sv
// Shared types and constants for the sample dispersion metric block.
// No dependencies.
`timescale 1ns / 1ps
package sdm_pkg;
   localparam int SDM_MAX_VALUES = 256;
   localparam logic [1:0] MODE_VAR   = 2'd0;
   localparam logic [1:0] MODE_MAD   = 2'd1;
   localparam logic [1:0] MODE_NN    = 2'd2;
   localparam logic [1:0] MODE_RANGE = 2'd3;
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FEW     = 2'd1;
   localparam logic [1:0] ST_DROP    = 2'd2;
   localparam logic [1:0] ST_SAT     = 2'd3;
   localparam logic [31:0] SAT_MAX   = 32'h7FFF_FFFF;

   typedef enum logic [3:0] {
      S_LOAD, S_RD_I, S_RD_J, S_ACC, S_NN_END, S_SQ_MUL, S_DIV_SET,
      S_DIV_RUN, S_DONE, S_OUT
   } sdm_state_type;
endpackage

### sv/sample_dispersion_metric.sv
// Sample dispersion metric: one sample set is loaded one value per transfer
// into a value RAM; values past MAX_VALUES are dropped and reported. After
// the value marked last, a small sequencer walks the RAM through one shared
// difference/accumulate unit. The range makes one pass over the values
// (read x_i, re-read it, update max/min), the mean pair distance and the
// variance visit each pair once (the variance adds a squaring step), and the
// mean nearest-neighbor distance scans a full row per value. The three
// averaged modes then go through the bit-serial divider (a setup state, a
// start, then the quotient bits one by one). Sets with fewer than two
// values skip all of this. The S_OUT state then moves the result into the
// output register, and only then is input ready again; a result still
// waiting in the output register holds the next result but not the next
// load. A result above 0x7FFFFFFF saturates.
// Depends on sdm_pkg, sdm_ram, sdm_divider and the assertion macro header.
`timescale 1ns / 1ps
`include "sample_dispersion_metric_macros.svh"
module sample_dispersion_metric import sdm_pkg::*; #(
   parameter int MAX_VALUES = SDM_MAX_VALUES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_trait_value,
   input  logic               req_last_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_metric_value,
   output logic [8:0]         rsp_value_total,
   output logic [1:0]         rsp_status_code,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_wr_data
);
   localparam int AW = $clog2(MAX_VALUES);
   localparam int CW = $clog2(MAX_VALUES + 1);
   localparam int PW = 2 * CW;
   localparam int NW = 112;

   sdm_state_type state_ff, state_in;
   logic [1:0]  mode_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        ovf_ff, ovf_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in;
   logic signed [32:0] xi_ff, xi_in;
   logic [32:0] best_ff, best_in;   // bit 32 set = none yet
   logic [NW-1:0] acc_ff, acc_in;
   logic [32:0] diff_ff, diff_in;
   logic [PW-1:0] pairs_ff, pairs_in;
   logic [31:0] res_ff, res_in;
   logic [1:0]  st_ff, st_in;
   logic        rv_ff, rv_in;
   logic [8:0]  tot_ff, tot_in;
   logic [31:0] out_res_ff, out_res_in;
   logic [1:0]  out_st_ff, out_st_in;

   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0] ram_q;
   logic        div_start, div_done, div_sat;
   logic [31:0] div_q;
   logic [NW-1:0] div_num;
   logic [PW-1:0] div_den;
   logic signed [32:0] xq, dsub;
   logic [32:0] ad;
   logic [63:0] sq;

   sdm_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(req_trait_value), .rd_data(ram_q));

   sdm_divider #(.NW(NW), .DW(PW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q),
      .saturated(div_sat));

   // shared difference unit; a distance always fits in 32 bits
   assign xq   = {ram_q[31], ram_q};
   assign dsub = xi_ff - xq;
   assign ad   = dsub[32] ? 33'(-dsub) : 33'(dsub);
   assign sq   = diff_ff[31:0] * diff_ff[31:0];

   assign req_ready        = (state_ff == S_LOAD);
   assign rsp_valid        = rv_ff;
   assign rsp_metric_value = out_res_ff;
   assign rsp_value_total  = tot_ff;
   assign rsp_status_code  = out_st_ff;

   always_comb begin
      state_in = state_ff; cnt_in = cnt_ff; ovf_in = ovf_ff;
      i_in = i_ff; j_in = j_ff; xi_in = xi_ff; best_in = best_ff;
      acc_in = acc_ff; diff_in = diff_ff; pairs_in = pairs_ff;
      res_in = res_ff; st_in = st_ff; rv_in = rv_ff; tot_in = tot_ff;
      out_res_in = out_res_ff; out_st_in = out_st_ff;
      ram_we = 1'b0; ram_addr = i_ff[AW-1:0];
      div_start = 1'b0;
      div_num = (mode_ff == MODE_VAR) ? (acc_ff >> 16) : acc_ff;
      div_den = pairs_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (state_ff)
         S_LOAD: begin
            ram_addr = cnt_ff[AW-1:0];
            if (req_valid && req_ready) begin
               if (cnt_ff < CW'(MAX_VALUES)) begin
                  ram_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_value) begin
                  i_in = '0; j_in = '0; acc_in = '0;
                  best_in = {1'b1, 32'd0};
                  state_in = S_RD_I;
                  if (cnt_in < CW'(2)) begin
                     res_in = '0; st_in = ST_FEW; state_in = S_OUT;
                  end
               end
            end
         end
         S_RD_I: begin
            // issue read of x_i
            ram_addr = i_ff[AW-1:0];
            j_in = (mode_ff == MODE_NN || mode_ff == MODE_RANGE) ? '0 : i_ff + 1'b1;
            state_in = S_RD_J;
         end
         S_RD_J: begin
            // x_i is on the read port; issue read of x_j (range re-reads x_i)
            xi_in = xq;
            ram_addr = (mode_ff == MODE_RANGE) ? i_ff[AW-1:0] : j_ff[AW-1:0];
            state_in = S_ACC;
         end
         S_ACC: begin
            // x_j on read port: range tracks max/min in acc[65:0]
            if (mode_ff == MODE_RANGE) begin
               // acc[32:0] = min, acc[65:33] = max (33-bit signed)
               if (i_ff == '0) begin
                  acc_in[32:0] = xq; acc_in[65:33] = xq;
               end else begin
                  if (xq < $signed(acc_ff[32:0]))  acc_in[32:0]  = xq;
                  if (xq > $signed(acc_ff[65:33])) acc_in[65:33] = xq;
               end
               i_in = i_ff + 1'b1;
               state_in = S_RD_I;
               if (i_ff + 1'b1 == cnt_ff) begin
                  diff_in = 33'($signed(acc_in[65:33]) - $signed(acc_in[32:0]));
                  state_in = S_DONE;
               end
            end else begin
               diff_in = ad;
               if (mode_ff == MODE_NN) begin
                  if (j_ff != i_ff && (best_ff[32] || ad < best_ff)) best_in = ad;
               end else if (mode_ff == MODE_MAD) begin
                  acc_in = acc_ff + NW'(ad);
               end
               state_in = (mode_ff == MODE_VAR) ? S_SQ_MUL : S_RD_J;
               if (mode_ff != MODE_VAR) begin
                  ram_addr = i_ff[AW-1:0];
                  j_in = j_ff + 1'b1;
                  if (j_ff + 1'b1 == cnt_ff) begin
                     state_in = (mode_ff == MODE_NN) ? S_NN_END : S_RD_I;
                     if (mode_ff == MODE_MAD) begin
                        i_in = i_ff + 1'b1;
                        if (i_ff + CW'(2) >= cnt_ff) state_in = S_DIV_SET;
                     end
                  end
               end
            end
         end
         S_SQ_MUL: begin
            acc_in = acc_ff + NW'(sq);
            ram_addr = i_ff[AW-1:0];
            j_in = j_ff + 1'b1;
            state_in = S_RD_J;
            if (j_ff + 1'b1 == cnt_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_RD_I;
               if (i_ff + CW'(2) >= cnt_ff) state_in = S_DIV_SET;
            end
         end
         S_NN_END: begin
            acc_in = acc_ff + NW'(best_ff[31:0]);
            best_in = {1'b1, 32'd0};
            i_in = i_ff + 1'b1;
            state_in = (i_ff + 1'b1 == cnt_ff) ? S_DIV_SET : S_RD_I;
         end
         S_DIV_SET: begin
            case (mode_ff)
               MODE_VAR: pairs_in = PW'(cnt_ff) * PW'(cnt_ff - 1'b1);
               MODE_MAD: pairs_in = (PW'(cnt_ff) * PW'(cnt_ff - 1'b1)) >> 1;
               default:  pairs_in = PW'(cnt_ff);
            endcase
            state_in = S_DIV_RUN;
            if (mode_ff != MODE_VAR) begin
               // mean of pairs or per-value minima
            end
         end
         S_DIV_RUN: begin
            div_start = (i_ff != '0);
            i_in = '0;
            if (div_done) begin
               res_in = div_q;
               st_in = div_sat ? ST_SAT : (ovf_ff ? ST_DROP : ST_OK);
               state_in = S_OUT;
            end
         end
         S_DONE: begin
            // range result in diff
            res_in = (diff_ff > 33'(SAT_MAX)) ? SAT_MAX : diff_ff[31:0];
            st_in = (diff_ff > 33'(SAT_MAX)) ? ST_SAT : (ovf_ff ? ST_DROP : ST_OK);
            state_in = S_OUT;
         end
         S_OUT: begin
            // move the finished result into the output register once it is free
            if (!rv_ff) begin
               rv_in = 1'b1;
               out_res_in = res_ff;
               out_st_in = st_ff;
               tot_in = 9'(cnt_ff);
               cnt_in = '0; ovf_in = 1'b0;
               state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         mode_ff  <= MODE_VAR;
         cnt_ff   <= '0;
         ovf_ff   <= 1'b0;
         rv_ff    <= 1'b0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) mode_ff <= csr_wr_data;
         cnt_ff   <= cnt_in;
         ovf_ff   <= ovf_in;
         rv_ff    <= rv_in;
         i_ff     <= i_in;
      end
      j_ff <= j_in; xi_ff <= xi_in; best_ff <= best_in; acc_ff <= acc_in;
      diff_ff <= diff_in; pairs_ff <= pairs_in; res_ff <= res_in;
      st_ff <= st_in; tot_ff <= tot_in;
      out_res_ff <= out_res_in; out_st_ff <= out_st_in;
   end

   `SDM_ASSERT(a_ready_only_load, clock, reset, req_ready |-> state_ff == S_LOAD, "ready outside load")
   `SDM_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= CW'(MAX_VALUES), "count over capacity")
   `SDM_ASSERT(a_few_status, clock, reset, (rsp_valid && rsp_value_total < 9'd2) |-> rsp_status_code == ST_FEW, "few status")
   `SDM_ASSERT(a_sat_value, clock, reset, (rsp_valid && rsp_status_code == ST_SAT) |-> rsp_metric_value == SAT_MAX, "sat value")
endmodule

### sv/sdm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### sv/sdm_divider.sv
// Restoring divider, one quotient bit per cycle, saturating quotient.
// Depends on sdm_pkg.
`timescale 1ns / 1ps
module sdm_divider import sdm_pkg::*; #(
   parameter int NW = 112,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [31:0]   quotient,
   output logic          saturated
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] num_ff, num_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;

   always_comb begin
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[DW-1:0], num_ff[NW-1]};
      if (start) begin
         num_in = dividend; rem_in = '0; quo_in = '0;
         cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in;
   end

   assign done      = busy_ff && (cnt_ff == CW'(1));
   assign saturated = (quo_in > NW'(SAT_MAX));
   assign quotient  = saturated ? SAT_MAX : quo_in[31:0];
endmodule
